// File: src/fconv_pkg.sv
package fconv_pkg;

  // Width of one convolution output word, Q2.30 plus guard bits.
  localparam int RESULT_W = 36;

  // Opcodes of the input word.
  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Controls one multiply-accumulate issue slot.
  typedef struct packed {
    logic clr;     // zero the accumulator
    logic issue;   // a tap/sample read pair was issued this cycle
    logic tap_ok;  // tap entry has been written since reset
    logic smp_ok;  // history entry holds a live sample
  } mac_ctl_t;

endpackage

// File: src/fconv_ram.sv
module fconv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/fconv_mac.sv
module fconv_mac
  import fconv_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mac_ctl_t               ctl,
  input  logic [SAMPLE_BITS-1:0] tap_rd,
  input  logic [SAMPLE_BITS-1:0] smp_rd,
  output logic                   busy,
  output logic [RESULT_W-1:0]    acc
);

  localparam int PW = 2 * SAMPLE_BITS;
  localparam int EW = (PW > RESULT_W) ? PW : RESULT_W;

  logic                    p1;
  logic                    p1_tap_ok;
  logic                    p1_smp_ok;
  logic                    p2;
  logic signed [PW-1:0]    prod;
  logic signed [SAMPLE_BITS-1:0] tap_s;
  logic signed [SAMPLE_BITS-1:0] smp_s;
  logic signed [EW-1:0]    prod_ext;

  // Entries never written read as zero.
  assign tap_s    = p1_tap_ok ? signed'(tap_rd) : '0;
  assign smp_s    = p1_smp_ok ? signed'(smp_rd) : '0;
  assign prod_ext = EW'(prod);
  assign busy     = p1 | p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
    end else begin
      p1 <= ctl.issue;
      p2 <= p1;
    end
    p1_tap_ok <= ctl.tap_ok;
    p1_smp_ok <= ctl.smp_ok;
    prod      <= tap_s * smp_s;
    if (ctl.clr) begin
      acc <= '0;
    end else if (p2) begin
      acc <= acc + prod_ext[RESULT_W-1:0];  // wraps to the result width
    end
  end

endmodule

// File: src/full_linear_convolution_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_stall  | opcode, value, tap_index, last
// output   | out_valid / out_stall| result, frame_end
//
// Steps: a tap load is taken in the idle state and gives no output word. A
//   sample is accepted, klen read issues go to the tap and history RAMs, the
//   multiplier and accumulator pipeline drains, and the output register is
//   loaded; each tail word of a frame repeats the issues, drain and load. The
//   single shared multiply-accumulate over the tap and history RAMs takes every pair.
// Reset: rst is synchronous, active high; taps and history read as zero and the
//   kernel length is one until written. No clearing pass is needed.
// Stalls: in_stall is high while a sample or its tail is in work; the block waits
//   in its last step while out_stall holds a pending word.
module full_linear_convolution_core
  import fconv_pkg::*;
#(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [15:0]         value,
  input  logic [3:0]                 tap_index,
  input  logic                       last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] result,
  output logic                       frame_end
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;  // RAM address width
  localparam int KW = $clog2(MAX_TAPS + 1);                   // holds 1..MAX_TAPS

  typedef enum logic [1:0] {IDLE, ISSUE, DRAIN, FINISH} state_t;

  state_t state;

  // Kernel and history bookkeeping.
  logic [MAX_TAPS-1:0]    tap_valid;
  logic [MAX_TAPS-1:0]    hist_valid;
  logic [KW-1:0]          klen;
  logic [AW-1:0]          head;       // slot of the newest history entry
  logic [KW-1:0]          j;          // tap index being issued
  logic [KW-1:0]          t;          // output count within the current sample
  logic                   last_r;

  logic [AW-1:0]          head_next;
  logic [AW:0]            hsum;
  logic [AW-1:0]          hist_addr;
  logic [AW-1:0]          tap_addr;
  logic [SAMPLE_BITS+15:0] value_ext;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   in_acc;
  logic                   tap_load;
  logic                   smp_load;
  logic                   idx_ok;
  logic                   out_free;
  logic                   end_word;
  logic                   tail_step;

  logic [SAMPLE_BITS-1:0] tap_rd;
  logic [SAMPLE_BITS-1:0] smp_rd;
  mac_ctl_t               mac_ctl;
  logic                   mac_busy;
  logic [RESULT_W-1:0]    acc;

  // Sample is the low SAMPLE_BITS of the port, zero-filled above 16 bits.
  assign value_ext = {{SAMPLE_BITS{1'b0}}, value};
  assign sample    = value_ext[SAMPLE_BITS-1:0];

  assign in_stall = (state != IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign tap_load = in_acc && (opcode == OP_TAP);
  assign smp_load = in_acc && (opcode == OP_SAMPLE);
  assign idx_ok   = (32'(tap_index) < MAX_TAPS);
  assign out_free = !out_valid || !out_stall;

  // Delay line is a circular buffer: shifting moves the head back one slot.
  assign head_next = (head == '0) ? AW'(MAX_TAPS - 1) : head - AW'(1);
  assign hsum      = {1'b0, head} + (AW + 1)'(j);
  assign hist_addr = (hsum >= (AW + 1)'(MAX_TAPS)) ? AW'(hsum - (AW + 1)'(MAX_TAPS))
                                                   : hsum[AW-1:0];
  assign tap_addr  = j[AW-1:0];

  // Word that closes the frame, and whether a zero-fed tail word follows.
  assign end_word  = last_r && ((t + KW'(1)) == klen);
  assign tail_step = (state == FINISH) && out_free && last_r && !end_word;

  always_comb begin
    mac_ctl.clr    = smp_load || tail_step;
    mac_ctl.issue  = (state == ISSUE);
    mac_ctl.tap_ok = tap_valid[tap_addr];
    mac_ctl.smp_ok = hist_valid[hist_addr];
  end

  fconv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_load && idx_ok),
    .waddr (AW'(tap_index)),
    .wdata (sample),
    .raddr (tap_addr),
    .rdata (tap_rd)
  );

  fconv_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (smp_load),
    .waddr (head_next),
    .wdata (sample),
    .raddr (hist_addr),
    .rdata (smp_rd)
  );

  fconv_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .tap_rd (tap_rd),
    .smp_rd (smp_rd),
    .busy   (mac_busy),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      tap_valid  <= '0;
      hist_valid <= '0;
      klen       <= KW'(1);
      head       <= '0;
      j          <= '0;
      t          <= '0;
      last_r     <= 1'b0;
    end else begin
      // Output register: load from the last step, else empty once taken.
      if ((state == FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (tap_load && idx_ok) begin
            tap_valid[AW'(tap_index)] <= 1'b1;
            if (last) begin
              klen <= KW'(tap_index) + KW'(1);
            end
          end
          if (smp_load) begin
            head                  <= head_next;
            hist_valid[head_next] <= 1'b1;
            last_r                <= last;
            t                     <= '0;
            j                     <= '0;
            state                 <= ISSUE;
          end
        end
        ISSUE: begin
          if ((j + KW'(1)) == klen) begin
            state <= DRAIN;
          end else begin
            j <= j + KW'(1);
          end
        end
        DRAIN: begin
          if (!mac_busy) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            result    <= acc;
            frame_end <= end_word;
            if (tail_step) begin
              // Shift a zero in: the new head slot simply reads as empty.
              head                  <= head_next;
              hist_valid[head_next] <= 1'b0;
              t                     <= t + KW'(1);
              j                     <= '0;
              state                 <= ISSUE;
            end else begin
              if (last_r) begin
                hist_valid <= '0;
              end
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: src/fconv_chk.sv
module fconv_chk
  import fconv_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                opcode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [RESULT_W-1:0] result,
  input logic                frame_end
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result) && $stable(frame_end))
    else $error("output word changed while stalled");

  // A sample occupies the block: no second word is taken right behind it.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_SAMPLE) |=> in_stall)
    else $error("input taken right after a sample");

  // Tap loads produce no output.
  a_tap_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_TAP) |=> !$rose(out_valid))
    else $error("output word after a tap load");

  // Reset empties the output register and frees the input.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind full_linear_convolution_core fconv_chk u_fconv_chk (.*);
